// ----- design/rv32idec_pkg.sv -----
// Package for the RV32I instruction decoder.
// Holds the item structs, the major opcodes, the operation and class codes.
// Depends on nothing.
package rv32idec_pkg;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] fetch_pc;
    } t_dec_in;

    typedef struct packed {
        logic [5:0]         op_code;
        logic [3:0]         class_code;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        pc_out;
    } t_dec_out;

    localparam logic [31:0] HALT_WORD = 32'h0ff0_0513;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_SUB     = 6'd1;
    localparam logic [5:0] OP_AND     = 6'd2;
    localparam logic [5:0] OP_OR      = 6'd3;
    localparam logic [5:0] OP_XOR     = 6'd4;
    localparam logic [5:0] OP_SLL     = 6'd5;
    localparam logic [5:0] OP_SRL     = 6'd6;
    localparam logic [5:0] OP_SRA     = 6'd7;
    localparam logic [5:0] OP_SLT     = 6'd8;
    localparam logic [5:0] OP_SLTU    = 6'd9;
    localparam logic [5:0] OP_ADDI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd11;
    localparam logic [5:0] OP_ORI     = 6'd12;
    localparam logic [5:0] OP_XORI    = 6'd13;
    localparam logic [5:0] OP_SLLI    = 6'd14;
    localparam logic [5:0] OP_SRLI    = 6'd15;
    localparam logic [5:0] OP_SRAI    = 6'd16;
    localparam logic [5:0] OP_SLTI    = 6'd17;
    localparam logic [5:0] OP_SLTIU   = 6'd18;
    localparam logic [5:0] OP_LB      = 6'd19;
    localparam logic [5:0] OP_LH      = 6'd20;
    localparam logic [5:0] OP_LW      = 6'd21;
    localparam logic [5:0] OP_LBU     = 6'd22;
    localparam logic [5:0] OP_LHU     = 6'd23;
    localparam logic [5:0] OP_SB      = 6'd24;
    localparam logic [5:0] OP_SH      = 6'd25;
    localparam logic [5:0] OP_SW      = 6'd26;
    localparam logic [5:0] OP_BEQ     = 6'd27;
    localparam logic [5:0] OP_BNE     = 6'd28;
    localparam logic [5:0] OP_BLT     = 6'd29;
    localparam logic [5:0] OP_BGE     = 6'd30;
    localparam logic [5:0] OP_BLTU    = 6'd31;
    localparam logic [5:0] OP_BGEU    = 6'd32;
    localparam logic [5:0] OP_JAL     = 6'd33;
    localparam logic [5:0] OP_JALR    = 6'd34;
    localparam logic [5:0] OP_LUI     = 6'd35;
    localparam logic [5:0] OP_AUIPC   = 6'd36;
    localparam logic [5:0] OP_EBREAK  = 6'd37;
    localparam logic [5:0] OP_ECALL   = 6'd38;
    localparam logic [5:0] OP_HALT    = 6'd39;
    localparam logic [5:0] OP_INVALID = 6'd40;

    localparam logic [3:0] CL_ALU     = 4'd0;
    localparam logic [3:0] CL_LOAD    = 4'd1;
    localparam logic [3:0] CL_STORE   = 4'd2;
    localparam logic [3:0] CL_BRANCH  = 4'd3;
    localparam logic [3:0] CL_JAL     = 4'd4;
    localparam logic [3:0] CL_JALR    = 4'd5;
    localparam logic [3:0] CL_UPPER   = 4'd6;
    localparam logic [3:0] CL_ENV     = 4'd7;
    localparam logic [3:0] CL_HALT    = 4'd8;
    localparam logic [3:0] CL_INVALID = 4'd9;

    localparam logic [31:0] SYS_MASK = 32'hffef_ff80;

endpackage

// ----- design/rv32i_instruction_decoder_core.sv -----
// Top level of the RV32I instruction decoder.
// Registers the item, decodes it in one pass and registers the result.
// Depends on rv32idec_pkg.
// Path: input register, combinational decode, then the result register.
// Throughput: one item per cycle unless i_out_ready holds the result register back.
// Reset: synchronous active-low reset empties both registers; payload is not reset.
module rv32i_instruction_decoder_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  rv32idec_pkg::t_dec_in  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output rv32idec_pkg::t_dec_out o_out_item
);
    import rv32idec_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    t_dec_in  r_in;
    logic     r_out_valid;
    logic     n_out_valid;
    t_dec_out r_out;
    t_dec_out n_out;
    logic     s_out_free;
    logic     s_in_take;

    assign s_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || s_out_free;
    assign s_in_take   = i_in_valid && o_in_ready;
    assign n_in_valid  = s_in_take ? 1'b1 : (s_out_free ? 1'b0 : r_in_valid);
    assign n_out_valid = s_out_free ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in <= i_in_item;
        end
        if (s_out_free) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        ok;
        logic [5:0]  op;
        logic [3:0]  cl;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] imm_u;

        w     = r_in.instr_word;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        imm_u = {w[31:12], 12'h000};
        ok    = 1'b0;
        op    = OP_INVALID;
        cl    = CL_INVALID;
        rd    = 5'd0;
        rs1   = 5'd0;
        rs2   = 5'd0;
        imm   = 32'd0;

        if (w == HALT_WORD) begin
            ok = 1'b1;
            op = OP_HALT;
            cl = CL_HALT;
        end else begin
            case (opc)
                OPC_OP: begin
                    ok  = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5));
                    cl  = CL_ALU;
                    rd  = w[11:7];
                    rs1 = w[19:15];
                    rs2 = w[24:20];
                    case (f3)
                        3'd0: op = (f7 == F7_ALT) ? OP_SUB : OP_ADD;
                        3'd1: op = OP_SLL;
                        3'd2: op = OP_SLT;
                        3'd3: op = OP_SLTU;
                        3'd4: op = OP_XOR;
                        3'd5: op = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
                        3'd6: op = OP_OR;
                        3'd7: op = OP_AND;
                        default: op = OP_INVALID;
                    endcase
                end
                OPC_OPIMM: begin
                    cl  = CL_ALU;
                    rd  = w[11:7];
                    rs1 = w[19:15];
                    ok  = 1'b1;
                    imm = imm_i;
                    case (f3)
                        3'd0: op = OP_ADDI;
                        3'd1: begin
                            op  = OP_SLLI;
                            ok  = (f7 == F7_BASE);
                            imm = {27'd0, w[24:20]};
                        end
                        3'd2: op = OP_SLTI;
                        3'd3: op = OP_SLTIU;
                        3'd4: op = OP_XORI;
                        3'd5: begin
                            op  = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
                            ok  = (f7 == F7_BASE) || (f7 == F7_ALT);
                            imm = {27'd0, w[24:20]};
                        end
                        3'd6: op = OP_ORI;
                        3'd7: op = OP_ANDI;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_LOAD: begin
                    cl  = CL_LOAD;
                    rd  = w[11:7];
                    rs1 = w[19:15];
                    imm = imm_i;
                    ok  = 1'b1;
                    case (f3)
                        3'd0: op = OP_LB;
                        3'd1: op = OP_LH;
                        3'd2: op = OP_LW;
                        3'd4: op = OP_LBU;
                        3'd5: op = OP_LHU;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_STORE: begin
                    cl  = CL_STORE;
                    rs1 = w[19:15];
                    rs2 = w[24:20];
                    imm = imm_s;
                    ok  = 1'b1;
                    case (f3)
                        3'd0: op = OP_SB;
                        3'd1: op = OP_SH;
                        3'd2: op = OP_SW;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_BRANCH: begin
                    cl  = CL_BRANCH;
                    rs1 = w[19:15];
                    rs2 = w[24:20];
                    imm = imm_b;
                    ok  = 1'b1;
                    case (f3)
                        3'd0: op = OP_BEQ;
                        3'd1: op = OP_BNE;
                        3'd4: op = OP_BLT;
                        3'd5: op = OP_BGE;
                        3'd6: op = OP_BLTU;
                        3'd7: op = OP_BGEU;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_JAL: begin
                    ok  = 1'b1;
                    op  = OP_JAL;
                    cl  = CL_JAL;
                    rd  = w[11:7];
                    imm = imm_j;
                end
                OPC_JALR: begin
                    ok  = (f3 == 3'd0);
                    op  = OP_JALR;
                    cl  = CL_JALR;
                    rd  = w[11:7];
                    rs1 = w[19:15];
                    imm = imm_i;
                end
                OPC_LUI: begin
                    ok  = 1'b1;
                    op  = OP_LUI;
                    cl  = CL_UPPER;
                    rd  = w[11:7];
                    imm = imm_u;
                end
                OPC_AUIPC: begin
                    ok  = 1'b1;
                    op  = OP_AUIPC;
                    cl  = CL_UPPER;
                    rd  = w[11:7];
                    imm = imm_u + r_in.fetch_pc;
                end
                OPC_SYSTEM: begin
                    ok = ((w & SYS_MASK) == 32'd0);
                    op = w[20] ? OP_EBREAK : OP_ECALL;
                    cl = CL_ENV;
                end
                default: ok = 1'b0;
            endcase
        end

        if (!ok) begin
            op  = OP_INVALID;
            cl  = CL_INVALID;
            rd  = 5'd0;
            rs1 = 5'd0;
            rs2 = 5'd0;
            imm = 32'd0;
        end

        n_out.op_code    = op;
        n_out.class_code = cl;
        n_out.dest_reg   = rd;
        n_out.src1_reg   = rs1;
        n_out.src2_reg   = rs2;
        n_out.immediate  = $signed(imm);
        n_out.pc_out     = r_in.fetch_pc;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
